### rtl/mpsa_pkg.sv
// shared constants, codes and types of the mixture position score accumulator
// no dependencies
package mpsa_pkg;

   localparam int CLUSTERS  = 8;
   localparam int POSITIONS = 256;
   localparam int SYMBOLS   = 32;

   localparam int CLUSTER_W = 3;
   localparam int POS_W     = 8;
   localparam int SYM_W     = 5;
   localparam int VALUE_W   = 24;
   localparam int SCORE_W   = 32;
   localparam int SEQ_W     = 16;
   localparam int LEN_W     = 9;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int ADDR_W    = POS_W + SYM_W;
   localparam int BANK_DEPTH = 1 << ADDR_W;

   localparam logic [LEN_W-1:0] LEN_MAX        = LEN_W'(256);
   localparam logic [SYM_W-1:0] GAP_CODE_RESET = SYM_W'(20);

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_SCORE = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEQ_LENGTH = 3'd0,
      CSR_START_COL  = 3'd1,
      CSR_END_COL    = 3'd2,
      CSR_GAP_SKIP   = 3'd3,
      CSR_GAP_CODE   = 3'd4
   } csr_idx_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic                   wr_en;
      logic [CLUSTER_W-1:0]   wr_cluster;
      logic                   rd_en;
      logic [ADDR_W-1:0]      addr;
      logic [VALUE_W-1:0]     wr_data;
      logic                   acc_en;
      logic                   add;
      logic                   last;
      logic                   shift;
   } cell_ctl_type;

   // one result slot of the output chain
   typedef struct packed {
      logic                   valid;
      logic [CLUSTER_W-1:0]   tag;
      logic [SCORE_W-1:0]     score;
   } slot_type;

endpackage

### rtl/mpsa_if.sv
// valid/ready channel interfaces for item, result and register write transfers
// depends on mpsa_pkg
interface mpsa_req_if;
   import mpsa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [CLUSTER_W-1:0] cluster;
   logic [POS_W-1:0]     position;
   logic [SYM_W-1:0]     symbol;
   logic signed [VALUE_W-1:0] value;
   modport source (output valid, command, cluster, position, symbol, value, input ready);
   modport sink   (input valid, command, cluster, position, symbol, value, output ready);
endinterface

interface mpsa_rsp_if;
   import mpsa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CLUSTER_W-1:0] cluster_index;
   logic [SEQ_W-1:0]     seq_index;
   logic signed [SCORE_W-1:0] score;
   logic                 last_of_run;
   modport source (output valid, cluster_index, seq_index, score, last_of_run, input ready);
   modport sink   (input valid, cluster_index, seq_index, score, last_of_run, output ready);
endinterface

interface mpsa_csr_if;
   import mpsa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/mpsa_cell.sv
// one cluster cell: table bank, saturating accumulator and output chain slot
// depends on mpsa_pkg
module mpsa_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mpsa_pkg::CLUSTER_W-1:0] cell_id,
   input  mpsa_pkg::cell_ctl_type        ctl,
   input  mpsa_pkg::slot_type            slot_next,
   output mpsa_pkg::slot_type            slot
);
   import mpsa_pkg::*;

   logic [VALUE_W-1:0] bank [BANK_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;
   logic [SCORE_W-1:0] sum_ff;
   logic [SCORE_W-1:0] sum_in;
   logic [SCORE_W:0]   wide_sum;
   logic [SCORE_W-1:0] total;
   logic [SCORE_W-1:0] addend;
   slot_type           slot_ff;
   slot_type           slot_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en && ctl.wr_cluster == cell_id) begin
         bank[ctl.addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= bank[ctl.addr];
      end
   end

   // saturating q15.16 add
   always_comb begin
      addend   = ctl.add ? {{(SCORE_W-VALUE_W){rd_data_ff[VALUE_W-1]}}, rd_data_ff} : '0;
      wide_sum = {sum_ff[SCORE_W-1], sum_ff} + {addend[SCORE_W-1], addend};
      if (wide_sum[SCORE_W] != wide_sum[SCORE_W-1]) begin
         total = wide_sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
      end else begin
         total = wide_sum[SCORE_W-1:0];
      end
   end

   always_comb begin
      sum_in  = sum_ff;
      slot_in = slot_ff;
      if (ctl.acc_en) begin
         sum_in = ctl.last ? '0 : total;
      end
      if (ctl.acc_en && ctl.last) begin
         slot_in.valid = 1'b1;
         slot_in.tag   = cell_id;
         slot_in.score = total;
      end else if (ctl.shift) begin
         slot_in = slot_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         slot_ff.valid <= 1'b0;
      end else begin
         sum_ff        <= sum_in;
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.tag   <= slot_in.tag;
      slot_ff.score <= slot_in.score;
   end

   assign slot = slot_ff;

endmodule

### rtl/mixture_position_score_accumulator.sv
// top level: register file, position sequencer and the row of cluster cells
// depends on mpsa_pkg, mpsa_if and mpsa_cell
//
// Scores symbol sequences against all clusters of a mixture. Load items
// (command 0) write one Q7.16 entry into the bank of the addressed cluster;
// score items (command 1) make every cluster cell read its bank at the
// current position and symbol and, in the column window and unless the symbol
// is a skipped gap code, add the entry into its Q15.16 saturating sum. The
// item enters a two-stage path: bank read into a register at acceptance,
// accumulate from it when the accumulate stage moves, so back-to-back items
// flow at one per cycle while no sequence end is held. At the last position
// of a sequence each cell drops its final sum into its slot of the output
// chain, which shifts one result per accepted response toward cell 0, giving
// cluster 0 first and last_of_run on the last cluster. A sequence end waits
// in the accumulate stage while the chain holds results of the previous
// sequence. Register writes are always taken.
module mixture_position_score_accumulator (
   input  logic            clock,
   input  logic            reset,
   mpsa_req_if.sink        req_ch,
   mpsa_rsp_if.source      rsp_ch,
   mpsa_csr_if.sink        csr_ch
);
   import mpsa_pkg::*;

   // configuration registers
   logic [LEN_W-1:0]   seq_length_ff;
   logic [LEN_W-1:0]   start_col_ff;
   logic [LEN_W-1:0]   end_col_ff;
   logic               gap_skip_ff;
   logic [SYM_W-1:0]   gap_code_ff;

   // sequencer state
   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic [SEQ_W-1:0]   seq_ff,   seq_in;
   logic [SEQ_W-1:0]   batch_seq_ff, batch_seq_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_add_ff,   s1_add_in;
   logic               s1_last_ff,  s1_last_in;

   logic               req_xfer;
   logic               is_score;
   logic               is_load;
   logic [LEN_W-1:0]   len_eff;
   logic [LEN_W-1:0]   pos_ext;
   logic               win_hit;
   logic               add_now;
   logic               last_now;
   logic               load_ok;
   logic               chain_free;
   logic               s1_go;
   logic               tail_busy;

   cell_ctl_type       ctl;
   slot_type           slots [CLUSTERS+1];

   // register write port, no back pressure
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_length_ff <= LEN_MAX;
         start_col_ff  <= '0;
         end_col_ff    <= LEN_MAX;
         gap_skip_ff   <= 1'b0;
         gap_code_ff   <= GAP_CODE_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_SEQ_LENGTH: seq_length_ff <= csr_ch.data[LEN_W-1:0];
            CSR_START_COL:  start_col_ff  <= csr_ch.data[LEN_W-1:0];
            CSR_END_COL:    end_col_ff    <= csr_ch.data[LEN_W-1:0];
            CSR_GAP_SKIP:   gap_skip_ff   <= csr_ch.data[0];
            CSR_GAP_CODE:   gap_code_ff   <= csr_ch.data[SYM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // decode of the incoming item
   assign req_xfer = req_ch.valid && req_ch.ready;
   assign is_score = req_ch.command == CMD_SCORE;
   assign is_load  = req_ch.command == CMD_LOAD;

   always_comb begin
      // length zero acts as one, anything past the table acts as the table
      if (seq_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (seq_length_ff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = seq_length_ff;
      end
      pos_ext  = {1'b0, pos_ff};
      win_hit  = (pos_ext >= start_col_ff) && (pos_ext < end_col_ff);
      add_now  = win_hit && !(gap_skip_ff && req_ch.symbol == gap_code_ff)
                 && (int'(pos_ff) < POSITIONS) && (int'(req_ch.symbol) < SYMBOLS);
      last_now = (pos_ext + LEN_W'(1)) >= len_eff;
      load_ok  = (int'(req_ch.cluster) < CLUSTERS) && (int'(req_ch.position) < POSITIONS)
                 && (int'(req_ch.symbol) < SYMBOLS);
   end

   // the output chain can take a new batch when it is empty or its last
   // result leaves in this cycle
   always_comb begin
      tail_busy = 1'b0;
      for (int k = 1; k < CLUSTERS; k++) begin
         tail_busy = tail_busy | slots[k].valid;
      end
   end
   assign chain_free = !tail_busy && (!slots[0].valid || rsp_ch.ready);

   // accumulate stage moves unless a sequence end meets a busy chain
   assign s1_go        = s1_valid_ff && (!s1_last_ff || chain_free);
   assign req_ch.ready = !s1_valid_ff || s1_go;

   always_comb begin
      pos_in       = pos_ff;
      seq_in       = seq_ff;
      batch_seq_in = batch_seq_ff;
      s1_valid_in  = s1_valid_ff;
      s1_add_in    = s1_add_ff;
      s1_last_in   = s1_last_ff;
      if (s1_go) begin
         s1_valid_in = 1'b0;
         if (s1_last_ff) begin
            batch_seq_in = seq_ff;
            seq_in       = seq_ff + SEQ_W'(1);
         end
      end
      if (req_xfer && is_score) begin
         s1_valid_in = 1'b1;
         s1_add_in   = add_now;
         s1_last_in  = last_now;
         pos_in      = last_now ? '0 : pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         seq_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         seq_ff      <= seq_in;
         s1_valid_ff <= s1_valid_in;
      end
      batch_seq_ff <= batch_seq_in;
      s1_add_ff    <= s1_add_in;
      s1_last_ff   <= s1_last_in;
   end

   // broadcast to the cells; loads address by their own position field
   always_comb begin
      ctl.wr_en      = req_xfer && is_load && load_ok;
      ctl.wr_cluster = req_ch.cluster;
      ctl.rd_en      = req_xfer && is_score;
      ctl.addr       = is_load ? {req_ch.position, req_ch.symbol} : {pos_ff, req_ch.symbol};
      ctl.wr_data    = req_ch.value;
      ctl.acc_en     = s1_go;
      ctl.add        = s1_add_ff;
      ctl.last       = s1_last_ff;
      ctl.shift      = rsp_ch.ready || !slots[0].valid;
   end

   // row of cluster cells; results shift toward cell 0
   assign slots[CLUSTERS] = '0;

   for (genvar k = 0; k < CLUSTERS; k++) begin : g_cell
      mpsa_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (CLUSTER_W'(k)),
         .ctl       (ctl),
         .slot_next (slots[k+1]),
         .slot      (slots[k])
      );
   end

   assign rsp_ch.valid         = slots[0].valid;
   assign rsp_ch.cluster_index = slots[0].tag;
   assign rsp_ch.seq_index     = batch_seq_ff;
   assign rsp_ch.score         = slots[0].score;
   assign rsp_ch.last_of_run   = slots[0].tag == CLUSTER_W'(CLUSTERS - 1);

endmodule
